@@ design/uud_pkg.sv @@
`timescale 1ns / 1ps

package uud_pkg;

  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
  localparam logic [7:0] CHAR_OFFSET    = 8'h20;

  // One decoded group as handed from the parser to the byte emitter.
  typedef struct packed {
    logic [23:0] bits;   // three bytes, first byte in the top bits
    logic [1:0]  cnt;    // bytes to emit, 1 to 3
    logic        ends;   // last byte of this group closes the line
  } job_t;

  // Six-bit value of one uuencoded character.
  function automatic logic [5:0] sixbit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_OFFSET;
    if (c == CHAR_BACKQUOTE) begin
      return 6'd0;
    end
    return d[5:0];
  endfunction

endpackage

@@ design/uudecode_line_decoder.sv @@
`timescale 1ns / 1ps

// Streaming uudecode: one text character enters per cycle on the in_ channel and
// decoded bytes leave one per cycle on the out_ channel while out_tready is high.
// A carriage return closes a line (extra carriage returns are skipped), the first
// character of each line is its byte count, and every four data characters decode
// to up to three bytes, limited by what the count still allows. A line that ends
// partway through a group flushes its pending bytes with the missing characters
// taken as zero. The parser accepts a character every cycle as long as the group
// queue (QUEUE_DEPTH entries) has room; the byte emitter sends one byte per cycle
// while out_tready is high. A completed group is written into the queue and then
// loaded into the emitter's registers before its bytes reach the output.
// out_tlast marks the final byte produced by one input character and out_tuser
// marks the byte that uses up a line's count or is flushed by a carriage return.
module uudecode_line_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // [0] line_end
);
  import uud_pkg::*;

  logic in_accept;
  logic job_valid;
  job_t front_job;
  job_t head_job;
  logic q_empty;
  logic q_full;
  logic q_pop;

  // Every accepted character can create at most one group, so a free queue
  // slot is all the parser needs to take the next one.
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  uud_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .char_in   (in_tdata),
    .job_valid (job_valid),
    .job       (front_job)
  );

  uud_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (front_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The emitter holds one group in registers and drives the output from them,
  // so it keeps working while the parser fills the queue behind it.
  uud_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (out_tdata),
    .out_last     (out_tlast),
    .out_line_end (out_tuser)
  );

endmodule

@@ design/uud_front.sv @@
`timescale 1ns / 1ps

module uud_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       char_in,
  output logic             job_valid,
  output uud_pkg::job_t    job
);
  import uud_pkg::*;

  logic        in_body_r, in_body_nxt;
  logic [5:0]  left_r, left_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] bits_r, bits_nxt;

  logic [5:0]  six;
  logic [1:0]  n;
  logic [5:0]  left_after;
  logic [23:0] flush_bits;

  assign six        = sixbit(char_in);
  assign n          = (left_r < 6'd3) ? left_r[1:0] : 2'd3;
  assign left_after = left_r - {4'd0, n};

  // Missing characters of a partial group are taken as zero.
  always_comb begin
    case (pos_r)
      2'd1:    flush_bits = {bits_r[5:0], 18'd0};
      2'd2:    flush_bits = {bits_r[11:0], 12'd0};
      2'd3:    flush_bits = {bits_r, 6'd0};
      default: flush_bits = 24'd0;
    endcase
  end

  always_comb begin
    in_body_nxt = in_body_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    bits_nxt    = bits_r;
    job_valid   = 1'b0;
    job.bits    = flush_bits;
    job.cnt     = n;
    job.ends    = 1'b1;
    if (accept) begin
      if (char_in == CHAR_CR) begin
        if (in_body_r) begin
          job_valid   = (pos_r != 2'd0) && (left_r != 6'd0);
          in_body_nxt = 1'b0;
          left_nxt    = 6'd0;
          pos_nxt     = 2'd0;
          bits_nxt    = 18'd0;
        end
      end else if (!in_body_r) begin
        in_body_nxt = 1'b1;
        left_nxt    = six;
        pos_nxt     = 2'd0;
        bits_nxt    = 18'd0;
      end else if (left_r != 6'd0) begin
        if (pos_r == 2'd3) begin
          job_valid = 1'b1;
          job.bits  = {bits_r, six};
          job.ends  = (left_after == 6'd0);
          left_nxt  = left_after;
          pos_nxt   = 2'd0;
          bits_nxt  = 18'd0;
        end else begin
          bits_nxt = {bits_r[11:0], six};
          pos_nxt  = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      left_r    <= 6'd0;
      pos_r     <= 2'd0;
      bits_r    <= 18'd0;
    end else begin
      in_body_r <= in_body_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      bits_r    <= bits_nxt;
    end
  end

endmodule

@@ design/uud_fifo.sv @@
`timescale 1ns / 1ps

module uud_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  uud_pkg::job_t    push_job,
  input  logic             pop,
  output uud_pkg::job_t    head_job,
  output logic             empty,
  output logic             full
);
  import uud_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [IW-1:0] wr_r, wr_nxt;
  logic [IW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty    = (cnt_r == CW'(0));
  assign full     = (cnt_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == IW'(DEPTH - 1)) ? IW'(0) : wr_r + IW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == IW'(DEPTH - 1)) ? IW'(0) : rd_r + IW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/uud_back.sv @@
`timescale 1ns / 1ps

module uud_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  uud_pkg::job_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_line_end
);
  import uud_pkg::*;

  logic       busy_r, busy_nxt;
  job_t       job_r, job_nxt;
  logic [1:0] k_r, k_nxt;
  logic       last_byte;
  logic       taken;

  assign last_byte    = (k_r + 2'd1 == job_r.cnt);
  assign taken        = busy_r && out_ready;
  assign out_valid    = busy_r;
  assign out_last     = last_byte;
  assign out_line_end = last_byte && job_r.ends;

  always_comb begin
    case (k_r)
      2'd0:    out_byte = job_r.bits[23:16];
      2'd1:    out_byte = job_r.bits[15:8];
      default: out_byte = job_r.bits[7:0];
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    k_nxt    = k_r;
    q_pop    = 1'b0;
    if (!busy_r || (taken && last_byte)) begin
      q_pop    = !q_empty;
      busy_nxt = !q_empty;
      job_nxt  = q_head;
      k_nxt    = 2'd0;
    end else if (taken) begin
      k_nxt = k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

endmodule

@@ bench/tb_uudecode_line_decoder.sv @@
`timescale 1ns / 1ps

// Drives uuencoded text into the line decoder one character per item and checks every
// decoded byte against the directed table or an in-bench model of the line parser.
// A short directed sequence comes first. Then random lines follow: mostly well-formed,
// some truncated or padded, and some pure noise.
module tb_uudecode_line_decoder;
  import uud_pkg::*;

  // One decoded byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       line_last;
  } dec_byte_t;

  // One directed character. When known is set, the expected bytes are given here.
  // Result k sits in bytes[23-8k -: 8], lasts[k] and ends[k].
  typedef struct packed {
    logic [7:0]  ch;
    logic        known;
    logic [1:0]  n;
    logic [23:0] bytes;
    logic [2:0]  lasts;
    logic [2:0]  ends;
  } stim_row_t;

  localparam int        NUM_DIRECTED  = 23;
  localparam int        RANDOM_ITEMS  = 350;
  localparam int        IDLE_PCT      = 32;
  localparam int        STALL_LIMIT   = 3000;
  localparam int        HOLD_CYCLES   = 300;
  localparam int        DRAIN_CYCLES  = 16;
  localparam logic [7:0] CHAR_FULL    = 8'h5F;  // decodes to 6'h3F
  localparam stim_row_t FREE_ROW      = '{8'h00, 1'b0, 2'd0, 24'h0, 3'b000, 3'b000};

  localparam stim_row_t DIR_ROWS [0:NUM_DIRECTED-1] = '{
    // Carriage returns with no line open are skipped.
    '{CHAR_CR,        1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_CR,        1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    // A backquote length opens an empty line, and its data is ignored.
    '{CHAR_BACKQUOTE, 1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{8'h41,          1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_CR,        1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    // Count of three with all-ones data. A fifth character is past the count.
    '{8'h23,          1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd3, 24'hFFFFFF, 3'b100, 3'b100},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_CR,        1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    // Count of six that closes on a group boundary, so the unused count is dropped.
    '{8'h26,          1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_FULL,      1'b1, 2'd3, 24'hFFFFFF, 3'b100, 3'b000},
    '{CHAR_CR,        1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    // Largest count, with extreme data characters, closed partway through a group.
    '{CHAR_FULL,      1'b1, 2'd0, 24'h0,     3'b000, 3'b000},
    '{8'h00,          1'b0, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_BACKQUOTE, 1'b0, 2'd0, 24'h0,     3'b000, 3'b000},
    '{8'hFF,          1'b0, 2'd0, 24'h0,     3'b000, 3'b000},
    '{CHAR_CR,        1'b0, 2'd0, 24'h0,     3'b000, 3'b000}
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  // Model state of the line parser.
  logic        line_open;
  logic [5:0]  count_left;
  logic [1:0]  held_chars;
  logic [17:0] held_bits;

  dec_byte_t   new_bytes[$];
  dec_byte_t   pending_bytes[$];
  stim_row_t   cur_row;
  int          chars_sent;
  int          err_count;
  int          stall_cycles;
  bit          calm;
  bit          hold_go;
  bit          hold_done;

  uudecode_line_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h20;
    if (c == CHAR_BACKQUOTE) begin
      return 6'd0;
    end
    return d[5:0];
  endfunction

  // Hands out up to three bytes of a group, limited by the count left on the line.
  task automatic emit_group(input logic [23:0] w, input bit force_end);
    int        n;
    bit        ends;
    dec_byte_t b;
    n = (count_left < 6'd3) ? int'(count_left) : 3;
    count_left = count_left - 6'(n);
    ends = force_end || (count_left == 6'd0);
    for (int k = 0; k < n; k++) begin
      b.data      = w[23 - 8 * k -: 8];
      b.run_last  = (k + 1 == n);
      b.line_last = (k + 1 == n) && ends;
      new_bytes.push_back(b);
    end
  endtask

  // Advances the parser model by one character and leaves its bytes in new_bytes.
  task automatic decode_char(input logic [7:0] c);
    logic [23:0] w;
    int          sh;
    new_bytes.delete();
    if (c == CHAR_CR) begin
      if (line_open) begin
        if (held_chars != 2'd0 && count_left != 6'd0) begin
          sh = 6 * (4 - int'(held_chars));
          w  = 24'(held_bits) << sh;
          emit_group(w, 1'b1);
        end
        line_open  = 1'b0;
        count_left = '0;
        held_chars = '0;
        held_bits  = '0;
      end
    end else if (!line_open) begin
      count_left = char_value(c);
      line_open  = 1'b1;
      held_chars = '0;
      held_bits  = '0;
    end else if (count_left != 6'd0) begin
      if (held_chars == 2'd3) begin
        w = {held_bits, char_value(c)};
        held_chars = '0;
        held_bits  = '0;
        emit_group(w, 1'b0);
      end else begin
        held_bits  = {held_bits[11:0], char_value(c)};
        held_chars = held_chars + 2'd1;
      end
    end
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Offers one character, waits until it is taken and then maybe leaves a gap.
  // Gap lengths are geometric, so about a third of the sender's cycles are idle.
  // Entered and left at a falling edge.
  task automatic send_char(input logic [7:0] c, input stim_row_t r);
    int gap;
    in_tdata  <= c;
    in_tvalid <= 1'b1;
    cur_row = r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (chars_sent >= NUM_DIRECTED + 120) hold_go = 1'b1;
    calm = (chars_sent >= NUM_DIRECTED + 200) && (chars_sent < NUM_DIRECTED + 270);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      gap = 1;
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      repeat (gap) @(negedge clk);
    end
  endtask

  // One random line: mostly well-formed, some truncated or padded, some pure noise.
  task automatic send_line();
    int         kind;
    int         n;
    int         nchars;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 255));
        send_char(c, FREE_ROW);
      end
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < 80) n = $urandom_range(1, 12);
      else if (kind < 90) n = 0;
      else n = $urandom_range(13, 63);
      if (n == 0 && $urandom_range(0, 1) == 1) c = CHAR_BACKQUOTE;
      else c = 8'h20 + 8'(n);
      send_char(c, FREE_ROW);
      nchars = ((n + 2) / 3) * 4;
      kind = $urandom_range(0, 99);
      if (kind < 15) nchars = $urandom_range(0, nchars);
      else if (kind < 25) nchars = nchars + $urandom_range(1, 5);
      for (int i = 0; i < nchars; i++) begin
        c = 8'($urandom_range(8'h20, 8'h60));
        send_char(c, FREE_ROW);
      end
      send_char(CHAR_CR, FREE_ROW);
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) send_char(CHAR_CR, FREE_ROW);
      end
    end
  endtask

  // Sampling side: records expectations for taken characters, checks taken bytes,
  // and ends the run when nothing moves for too long.
  always @(posedge clk) begin
    dec_byte_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_char(in_tdata);
        if (cur_row.known) begin
          for (int k = 0; k < int'(cur_row.n); k++) begin
            want.data      = cur_row.bytes[23 - 8 * k -: 8];
            want.run_last  = cur_row.lasts[k];
            want.line_last = cur_row.ends[k];
            pending_bytes.push_back(want);
          end
        end else begin
          foreach (new_bytes[k]) pending_bytes.push_back(new_bytes[k]);
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_bytes.size() == 0) begin
          note_error($sformatf("unexpected byte %02h last=%0b end=%0b",
                               out_tdata, out_tlast, out_tuser));
        end else begin
          want = pending_bytes.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.run_last ||
              out_tuser !== want.line_last) begin
            note_error($sformatf("byte exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.data, want.run_last, want.line_last,
                                 out_tdata, out_tlast, out_tuser));
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_uudecode_line_decoder: errors");
          $finish;
        end
      end
    end
  end

  // Receiving side: random back-pressure, one long hold-off while the sender keeps going.
  initial begin
    int hold_count;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_tready <= 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
        hold_done = 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    line_open    = 1'b0;
    count_left   = '0;
    held_chars   = '0;
    held_bits    = '0;
    cur_row      = FREE_ROW;
    chars_sent   = 0;
    err_count    = 0;
    stall_cycles = 0;
    calm         = 1'b0;
    hold_go      = 1'b0;
    hold_done    = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_char(DIR_ROWS[i].ch, DIR_ROWS[i]);
    end
    while (chars_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      send_line();
    end
    in_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      note_error($sformatf("%0d bytes never arrived", pending_bytes.size()));
    end
    if (err_count == 0) begin
      $display("tb_uudecode_line_decoder: clean");
    end else begin
      $display("tb_uudecode_line_decoder: errors");
    end
    $finish;
  end

endmodule
